### sv/edsp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package edsp_pkg;

   // Width of line numbers and counts; values saturate at all ones.
   localparam int LINE_BITS = 24;

   // Engine phases.
   localparam logic [3:0] PH_CMD  = 4'd0;
   localparam logic [3:0] PH_NUM1 = 4'd1;
   localparam logic [3:0] PH_NUM2 = 4'd2;
   localparam logic [3:0] PH_COPY = 4'd3;
   localparam logic [3:0] PH_DEL  = 4'd4;
   localparam logic [3:0] PH_APP  = 4'd5;
   localparam logic [3:0] PH_TAIL = 4'd6;
   localparam logic [3:0] PH_DONE = 4'd7;
   localparam logic [3:0] PH_EFMT = 4'd8;
   localparam logic [3:0] PH_ESRC = 4'd9;

   // Status codes reported with every result word.
   localparam logic [1:0] ST_WORKING = 2'd0;
   localparam logic [1:0] ST_DONE    = 2'd1;
   localparam logic [1:0] ST_EFORMAT = 2'd2;
   localparam logic [1:0] ST_ESOURCE = 2'd3;

   // Stream selector carried with each input word.
   localparam logic REQ_SCRIPT = 1'b0;
   localparam logic REQ_SOURCE = 1'b1;

   // Characters of the script syntax.
   localparam logic [7:0] CHAR_A    = 8'h61;
   localparam logic [7:0] CHAR_D    = 8'h64;
   localparam logic [7:0] CHAR_SP   = 8'h20;
   localparam logic [7:0] CHAR_NL   = 8'h0A;
   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_NINE = 8'h39;

   typedef struct packed {
      logic       req_type;
      logic [7:0] data_byte;
      logic       script_last;
      logic       source_end;
   } item_type;

   typedef struct packed {
      logic       out_valid;
      logic [7:0] out_byte;
      logic       want_source;
      logic [1:0] status;
   } result_type;

endpackage

`default_nettype wire

### sv/edsp_in_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module edsp_in_stage (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               take,
   input  wire edsp_pkg::item_type item,
   input  wire logic               advance,
   output logic                    held_valid,
   output edsp_pkg::item_type      held_item
);
   import edsp_pkg::*;

   logic     valid_ff;
   logic     valid_in;
   item_type item_ff;

   // A word leaves when the engine advances and a new one may land in the same cycle.
   assign valid_in = take | (valid_ff & ~advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= item;
      end
   end

   assign held_valid = valid_ff;
   assign held_item  = item_ff;

endmodule

`default_nettype wire

### sv/edsp_engine.sv
`timescale 1ns / 1ps
`default_nettype none

module edsp_engine (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               fire,
   input  wire edsp_pkg::item_type item,
   output edsp_pkg::result_type    result
);
   import edsp_pkg::*;

   localparam logic [LINE_BITS-1:0] LINE_MAX = '1;

   logic [3:0]           phase_ff,   phase_in;
   logic                 append_ff,  append_in;
   logic [LINE_BITS-1:0] target_ff,  target_in;
   logic [LINE_BITS-1:0] count_ff,   count_in;
   logic [LINE_BITS-1:0] current_ff, current_in;
   logic                 sdone_ff,   sdone_in;

   logic [3:0] step_phase;
   logic       terminal;
   logic       want_now;
   logic       is_digit;
   logic       is_nl;
   logic       ovalid;
   logic [7:0] obyte;

   // Multiply by ten and add one decimal digit, saturating at all ones.
   function automatic logic [LINE_BITS-1:0] add_digit(input logic [LINE_BITS-1:0] v,
                                                      input logic [3:0] d);
      logic [LINE_BITS+3:0] r;
      r = ({4'b0, v} << 3) + ({4'b0, v} << 1) + {{LINE_BITS{1'b0}}, d};
      if (r > {4'b0, LINE_MAX}) begin
         return LINE_MAX;
      end
      return r[LINE_BITS-1:0];
   endfunction

   assign terminal = phase_ff inside {PH_DONE, PH_EFMT, PH_ESRC};
   assign want_now = phase_ff inside {PH_COPY, PH_DEL, PH_TAIL};
   assign is_digit = (item.data_byte >= CHAR_ZERO) && (item.data_byte <= CHAR_NINE);
   assign is_nl    = item.data_byte == CHAR_NL;

   always_comb begin
      step_phase = phase_ff;
      append_in  = append_ff;
      target_in  = target_ff;
      count_in   = count_ff;
      current_in = current_ff;
      sdone_in   = sdone_ff;
      ovalid     = 1'b0;
      obyte      = 8'h00;

      if (fire && !terminal && (item.req_type == want_now)) begin
         if (item.req_type == REQ_SCRIPT) begin
            if (item.script_last) begin
               sdone_in = 1'b1;
            end
            case (phase_ff)
               PH_CMD: begin
                  if ((item.data_byte == CHAR_A) || (item.data_byte == CHAR_D)) begin
                     append_in  = item.data_byte == CHAR_A;
                     target_in  = '0;
                     count_in   = '0;
                     step_phase = item.script_last ? PH_EFMT : PH_NUM1;
                  end else begin
                     step_phase = PH_EFMT;
                  end
               end
               PH_NUM1: begin
                  if (is_digit) begin
                     target_in = add_digit(target_ff, item.data_byte[3:0]);
                     if (item.script_last) begin
                        step_phase = PH_EFMT;
                     end
                  end else if (item.data_byte == CHAR_SP) begin
                     step_phase = item.script_last ? PH_EFMT : PH_NUM2;
                  end else begin
                     step_phase = PH_EFMT;
                  end
               end
               PH_NUM2: begin
                  if (is_digit) begin
                     count_in = add_digit(count_ff, item.data_byte[3:0]);
                     if (item.script_last) begin
                        step_phase = PH_EFMT;
                     end
                  end else if (is_nl) begin
                     step_phase = PH_COPY;
                  end else begin
                     step_phase = PH_EFMT;
                  end
               end
               default: begin
                  // Appending: the script byte goes straight to the output.
                  ovalid = 1'b1;
                  obyte  = item.data_byte;
                  if (is_nl && (count_ff != '0)) begin
                     count_in = count_ff - 1'b1;
                  end
               end
            endcase
         end else begin
            if (phase_ff == PH_TAIL) begin
               if (item.source_end) begin
                  step_phase = PH_DONE;
               end else begin
                  ovalid = 1'b1;
                  obyte  = item.data_byte;
               end
            end else if (item.source_end) begin
               step_phase = PH_ESRC;
            end else if (phase_ff == PH_COPY) begin
               ovalid = 1'b1;
               obyte  = item.data_byte;
               if (is_nl && (current_ff != LINE_MAX)) begin
                  current_in = current_ff + 1'b1;
               end
            end else begin
               if (is_nl) begin
                  if (current_ff != LINE_MAX) begin
                     current_in = current_ff + 1'b1;
                  end
                  if (count_ff != '0) begin
                     count_in = count_ff - 1'b1;
                  end
               end
            end
         end
      end
   end

   // Fall through the phases that need no further word.
   always_comb begin
      phase_in = step_phase;
      if ((phase_in == PH_COPY) && (current_in >= target_in)) begin
         phase_in = append_in ? PH_APP : PH_DEL;
      end
      if (((phase_in == PH_DEL) || (phase_in == PH_APP)) && (count_in == '0)) begin
         phase_in = sdone_in ? PH_TAIL : PH_CMD;
      end
      if ((phase_in == PH_APP) && sdone_in && (count_in != '0)) begin
         phase_in = PH_EFMT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_CMD;
         append_ff  <= 1'b0;
         target_ff  <= '0;
         count_ff   <= '0;
         current_ff <= '0;
         sdone_ff   <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         append_ff  <= append_in;
         target_ff  <= target_in;
         count_ff   <= count_in;
         current_ff <= current_in;
         sdone_ff   <= sdone_in;
      end
   end

   always_comb begin
      result.out_valid   = ovalid;
      result.out_byte    = obyte;
      result.want_source = phase_in inside {PH_COPY, PH_DEL, PH_TAIL};
      case (phase_in)
         PH_DONE: result.status = ST_DONE;
         PH_EFMT: result.status = ST_EFORMAT;
         PH_ESRC: result.status = ST_ESOURCE;
         default: result.status = ST_WORKING;
      endcase
   end

endmodule

`default_nettype wire

### sv/edsp_out_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module edsp_out_stage (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 load,
   input  wire edsp_pkg::result_type result,
   input  wire logic                 taken,
   output logic                      out_valid,
   output edsp_pkg::result_type      out_result
);
   import edsp_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   result_type result_ff;

   assign valid_in = load | (valid_ff & ~taken);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result;
      end
   end

   assign out_valid  = valid_ff;
   assign out_result = result_ff;

endmodule

`default_nettype wire

### sv/ed_script_patch_applier_unit.sv
// Flow: an accepted word is held in the input register and moves into the result register
// (raising rsp_tvalid) when the result side is free.
// Throughput: one word per cycle while the result side is not stalled; the engine state
// updates once per advance of the single input register into the result register.
// Reset: synchronous, active high; the engine returns to waiting for a command letter
// with all counts at zero, and both pipeline registers are emptied.
`timescale 1ns / 1ps
`default_nettype none

module ed_script_patch_applier_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // data_byte
   input  wire logic [1:0]  req_tuser,   // [0] req_type, [1] source_end
   input  wire logic        req_tlast,   // script_last
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // [7:0] out_byte, [8] want_source, [10:9] status
   output logic             rsp_tuser    // out_valid
);
   import edsp_pkg::*;

   item_type   req_item;
   item_type   held_item;
   logic       held_valid;
   logic       advance;
   result_type step_result;
   result_type rsp_result;

   // The input register moves into the result register whenever the result register
   // is empty or is being emptied in this same cycle.  The engine state changes only
   // on such an advance, so every word is applied exactly once.
   assign advance    = held_valid & (~rsp_tvalid | rsp_tready);
   assign req_tready = ~held_valid | advance;

   always_comb begin
      req_item.req_type    = req_tuser[0];
      req_item.data_byte   = req_tdata;
      req_item.script_last = req_tlast;
      req_item.source_end  = req_tuser[1];
   end

   edsp_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .take       (req_tvalid & req_tready),
      .item       (req_item),
      .advance    (advance),
      .held_valid (held_valid),
      .held_item  (held_item)
   );

   // Parser, line counters and phase sequencing for one word per cycle, on each advance.
   edsp_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .item   (held_item),
      .result (step_result)
   );

   edsp_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .load       (advance),
      .result     (step_result),
      .taken      (rsp_tready),
      .out_valid  (rsp_tvalid),
      .out_result (rsp_result)
   );

   assign rsp_tdata = {5'b0, rsp_result.status, rsp_result.want_source, rsp_result.out_byte};
   assign rsp_tuser = rsp_result.out_valid;

endmodule

`default_nettype wire

### sv/edsp_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module edsp_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [15:0] rsp_tdata,
   input wire logic        rsp_tuser
);
   import edsp_pkg::*;

   logic [1:0] pending_ff, pending_in;
   logic       term_ff, term_in;
   logic [1:0] status_ff, status_in;
   logic       req_fire;
   logic       rsp_fire;

   assign req_fire = req_tvalid & req_tready;
   assign rsp_fire = rsp_tvalid & rsp_tready;

   // Words accepted whose result has not yet been taken.
   assign pending_in = pending_ff + {1'b0, req_fire} - {1'b0, rsp_fire};
   assign term_in    = term_ff | (rsp_fire & (rsp_tdata[10:9] != ST_WORKING));
   assign status_in  = (rsp_fire && !term_ff) ? rsp_tdata[10:9] : status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 2'd0;
         term_ff    <= 1'b0;
         status_ff  <= ST_WORKING;
      end else begin
         pending_ff <= pending_in;
         term_ff    <= term_in;
         status_ff  <= status_in;
      end
   end

   // A stalled result word holds still.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result word changed while stalled");

   // No result word without an accepted input word behind it.
   a_no_invent: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> pending_ff != 2'd0)
      else $error("result word without an input word");

   // Once a final status is delivered it is reported for good.
   a_term_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && term_ff |-> rsp_tdata[10:9] == status_ff && !rsp_tuser)
      else $error("final status did not stick");

   // A final status never asks for more source text, and idle bytes are zero.
   a_term_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[10:9] != ST_WORKING || !rsp_tuser) |->
         (rsp_tdata[10:9] == ST_WORKING || !rsp_tdata[8]) &&
         (rsp_tuser || rsp_tdata[7:0] == 8'h00))
      else $error("inconsistent result fields");

endmodule

bind ed_script_patch_applier_unit edsp_checker u_edsp_checker (.*);

`default_nettype wire
